FILE: hdl/tksel_pkg.sv
package tksel_pkg;

    // Fixed field widths
    localparam int DATA_W       = 32;
    localparam int CAP_W        = 5;
    localparam int COUNT_OUT_W  = 5;
    localparam int MAX_KEPT_DEF = 16;

    // Register reset values
    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic             MODE_RESET = 1'b0;

    // Input operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Register select, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MODE     = 1'b1;

    // What every cell does on a transfer
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_POP,
        CELL_INSERT,
        CELL_EVICT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     keep_largest;
    } t_cell_ctrl;

    // True if a ranks strictly worse than b in the current mode
    function automatic logic worse(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b,
                                   input logic                     keep_largest);
        logic r;
        r = keep_largest ? (a < b) : (b < a);
        return r;
    endfunction

endpackage

FILE: hdl/tksel_cell.sv
module tksel_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                                  i_clk,
    input  tksel_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [CW-1:0]                         i_count,
    input  logic signed [tksel_pkg::DATA_W-1:0]   i_value,
    input  logic                                  i_lo_worse,
    input  logic signed [tksel_pkg::DATA_W-1:0]   i_lo_value,
    input  logic                                  i_hi_worse,
    input  logic signed [tksel_pkg::DATA_W-1:0]   i_hi_value,
    output logic                                  o_worse,
    output logic signed [tksel_pkg::DATA_W-1:0]   o_value,
    output logic signed [tksel_pkg::DATA_W-1:0]   o_next_value
);

    localparam logic IS_FIRST = (IDX == 0);

    logic signed [tksel_pkg::DATA_W-1:0] r_value;
    logic signed [tksel_pkg::DATA_W-1:0] n_value;
    logic                                occupied;

    // Cells are held worst first; cell 0 is the top
    assign occupied = (i_count > CW'(IDX));
    assign o_worse  = occupied &&
                      tksel_pkg::worse(r_value, i_value, i_ctrl.keep_largest);

    // Next value: hold, shift down, or take part in an insert
    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            tksel_pkg::CELL_HOLD: begin
                n_value = r_value;
            end
            tksel_pkg::CELL_POP: begin
                n_value = i_hi_value;
            end
            tksel_pkg::CELL_INSERT: begin
                // worse values stay, better ones move up one place
                if (o_worse) begin
                    n_value = r_value;
                end else if (i_lo_worse) begin
                    n_value = i_value;
                end else begin
                    n_value = i_lo_value;
                end
            end
            tksel_pkg::CELL_EVICT: begin
                // top dropped: the chain shifts down, then inserts
                if (i_hi_worse) begin
                    n_value = i_hi_value;
                end else if (IS_FIRST || o_worse) begin
                    n_value = i_value;
                end else begin
                    n_value = r_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

FILE: hdl/bounded_top_k_selector_core.sv
// Bounded top-K selector.
// Input channel (i_in_valid / o_in_ready) carries an op and a signed value:
// op push offers the value, op pop removes the worst kept value (the top).
// Output channel (o_out_valid / i_out_ready) returns one result per input
// transfer: the top value, whether a push was kept, the count held after
// the operation and an error flag for a pop on an empty store.
// Throughput is one item per cycle while the receiver takes results; the
// result appears in the cycle after the input transfer. The rate is set
// by the chain of cells: each cell holds one kept value, compares it with
// the incoming value and takes its own, its neighbour's or the new value.
// The output register lets a new item in whenever the held result is being
// taken; while the receiver stalls, o_in_ready drops and the result holds.
// Reset (synchronous, active low) empties the store, sets capacity to 16
// and selects the keep-smallest mode. Stored values need no clearing.
// The APB port sets capacity (0x0) and mode (0x4); writes are taken only
// while the store is empty.
module bounded_top_k_selector_core #(
    parameter int MAX_KEPT = tksel_pkg::MAX_KEPT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_op,
    input  logic signed [tksel_pkg::DATA_W-1:0]   i_value,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [tksel_pkg::DATA_W-1:0]   o_result_value,
    output logic                                  o_accepted,
    output logic [tksel_pkg::COUNT_OUT_W-1:0]     o_count,
    output logic                                  o_empty_error,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int EW = (CW > tksel_pkg::CAP_W) ? CW : tksel_pkg::CAP_W;

    logic                                r_out_valid;
    logic signed [tksel_pkg::DATA_W-1:0] r_result_value;
    logic                                r_accepted;
    logic [tksel_pkg::COUNT_OUT_W-1:0]   r_count_out;
    logic                                r_empty_error;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic [tksel_pkg::CAP_W-1:0]         r_cap;
    logic                                r_mode;

    logic                                xfer;
    logic                                cfg_wr;
    logic [EW-1:0]                       cap_ext;
    logic [EW-1:0]                       cap_clamped;
    logic [CW-1:0]                       eff_cap;
    logic                                full;
    logic                                reject;
    logic                                n_accepted;
    logic                                n_empty_error;
    logic signed [tksel_pkg::DATA_W-1:0] n_result_value;
    logic [EW-1:0]                       count_ext;
    tksel_pkg::t_cell_ctrl               ctrl;

    logic signed [tksel_pkg::DATA_W-1:0] cell_value [0:MAX_KEPT];
    logic signed [tksel_pkg::DATA_W-1:0] cell_next  [0:MAX_KEPT-1];
    logic                                cell_worse [0:MAX_KEPT];

    assign xfer       = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Effective capacity, clamped to 1..MAX_KEPT
    assign cap_ext = EW'(r_cap);
    always_comb begin
        if (cap_ext == '0) begin
            cap_clamped = EW'(1);
        end else if (cap_ext > EW'(MAX_KEPT)) begin
            cap_clamped = EW'(MAX_KEPT);
        end else begin
            cap_clamped = cap_ext;
        end
    end
    assign eff_cap = cap_clamped[CW-1:0];

    assign full   = (r_count >= eff_cap);
    assign reject = full && tksel_pkg::worse(i_value, cell_value[0], r_mode);

    // Operation decode for the cell chain and the result fields
    always_comb begin
        ctrl.keep_largest = r_mode;
        ctrl.op           = tksel_pkg::CELL_HOLD;
        n_count           = r_count;
        n_accepted        = 1'b0;
        n_empty_error     = 1'b0;
        n_result_value    = cell_next[0];
        if (xfer) begin
            if (i_op == tksel_pkg::OP_POP) begin
                if (r_count == '0) begin
                    n_empty_error  = 1'b1;
                    n_result_value = '0;
                end else begin
                    ctrl.op        = tksel_pkg::CELL_POP;
                    n_count        = r_count - 1'b1;
                    n_result_value = cell_value[0];
                end
            end else if (!reject) begin
                n_accepted = 1'b1;
                if (full) begin
                    ctrl.op = tksel_pkg::CELL_EVICT;
                end else begin
                    ctrl.op = tksel_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // Chain of cells, worst value at cell 0
    assign cell_value[MAX_KEPT] = '0;
    assign cell_worse[MAX_KEPT] = 1'b0;

    genvar j;
    generate
        for (j = 0; j < MAX_KEPT; j++) begin : g_cell
            logic                                lo_worse;
            logic signed [tksel_pkg::DATA_W-1:0] lo_value;
            if (j == 0) begin : g_first
                assign lo_worse = 1'b1;
                assign lo_value = i_value;
            end else begin : g_rest
                assign lo_worse = cell_worse[j-1];
                assign lo_value = cell_value[j-1];
            end
            tksel_cell #(
                .IDX (j),
                .CW  (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_count      (r_count),
                .i_value      (i_value),
                .i_lo_worse   (lo_worse),
                .i_lo_value   (lo_value),
                .i_hi_worse   (cell_worse[j+1]),
                .i_hi_value   (cell_value[j+1]),
                .o_worse      (cell_worse[j]),
                .o_value      (cell_value[j]),
                .o_next_value (cell_next[j])
            );
        end
    endgenerate

    // Count and configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= tksel_pkg::CAP_RESET;
            r_mode  <= tksel_pkg::MODE_RESET;
        end else begin
            r_count <= n_count;
            if (cfg_wr && (r_count == '0)) begin
                if (paddr[2] == tksel_pkg::REG_CAPACITY) begin
                    r_cap <= pwdata[tksel_pkg::CAP_W-1:0];
                end else begin
                    r_mode <= pwdata[0];
                end
            end
        end
    end

    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == tksel_pkg::REG_MODE) begin
            prdata = {31'd0, r_mode};
        end else begin
            prdata = {{(32 - tksel_pkg::CAP_W){1'b0}}, r_cap};
        end
    end

    // Output register
    assign count_ext = EW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_result_value <= n_result_value;
            r_accepted     <= n_accepted;
            r_count_out    <= count_ext[tksel_pkg::COUNT_OUT_W-1:0];
            r_empty_error  <= n_empty_error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result_value;
    assign o_accepted     = r_accepted;
    assign o_count        = r_count_out;
    assign o_empty_error  = r_empty_error;

`ifndef SYNTH
    // Never more values held than the effective capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= eff_cap)
        else $error("held count above capacity");

    // Every input transfer leaves a result in the output register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |=> o_out_valid)
        else $error("no result after input transfer");

    // An empty-store pop reports nothing held and nothing kept
    a_empty_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_error) |-> (o_count == '0) && !o_accepted)
        else $error("empty error with non-zero count or accept");

    // A push into a store that is not full grows the count by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && (i_op == tksel_pkg::OP_PUSH) && !full)
            |=> (r_count == $past(r_count) + 1'b1))
        else $error("push below capacity did not grow the count");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int          DATA_W      = tksel_pkg::DATA_W;
    localparam int          CAP_W       = tksel_pkg::CAP_W;
    localparam int          COUNT_OUT_W = tksel_pkg::COUNT_OUT_W;
    localparam int          MAX_KEPT    = tksel_pkg::MAX_KEPT_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic KEEP_SMALLEST = 1'b0;
    localparam logic KEEP_LARGEST  = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic                      accepted;
        logic [COUNT_OUT_W-1:0]    count;
        logic                      empty_error;
    } t_topk_result;

    // DUT signals
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_op;
    logic signed [DATA_W-1:0]   i_value;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [DATA_W-1:0]   o_result_value;
    logic                       o_accepted;
    logic [COUNT_OUT_W-1:0]     o_count;
    logic                       o_empty_error;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    bounded_top_k_selector_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_accepted     (o_accepted),
        .o_count        (o_count),
        .o_empty_error  (o_empty_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow of the store: sorted best first, top at held-1
    logic signed [DATA_W-1:0] shadow_kept [MAX_KEPT];
    int unsigned              shadow_held;
    logic [CAP_W-1:0]         shadow_cap_reg;
    logic                     shadow_largest;

    t_topk_result  pending_results [$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    logic          idle_on;
    int unsigned   stall_left;

    // a ranks strictly below b under the current mode
    function automatic logic ranks_below(input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b);
        return shadow_largest ? (a < b) : (a > b);
    endfunction

    // Apply one operation to the shadow store and return its result
    function automatic t_topk_result topk_apply(input logic op,
                                                input logic signed [DATA_W-1:0] v);
        t_topk_result r;
        int unsigned  lim;
        int unsigned  i;
        logic         take;
        r = '0;
        if (op == tksel_pkg::OP_POP) begin
            if (shadow_held == 0) begin
                r.empty_error = 1'b1;
            end else begin
                shadow_held = shadow_held - 1;
                r.value = shadow_kept[shadow_held];
            end
        end else begin
            lim = (shadow_cap_reg == 0) ? 1 :
                  ((shadow_cap_reg > MAX_KEPT) ? MAX_KEPT : shadow_cap_reg);
            take = 1'b1;
            if (shadow_held >= lim) begin
                take = !ranks_below(v, shadow_kept[shadow_held-1]);
                // evict the top
                if (take) shadow_held = lim - 1;
            end
            if (take) begin
                r.accepted = 1'b1;
                i = shadow_held;
                while (i > 0 && ranks_below(shadow_kept[i-1], v)) begin
                    shadow_kept[i] = shadow_kept[i-1];
                    i = i - 1;
                end
                shadow_kept[i] = v;
                shadow_held = shadow_held + 1;
            end
            r.value = shadow_kept[shadow_held-1];
        end
        r.count = shadow_held[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Offer one item; predict its result at the accepting edge
    task automatic send_item(input logic op, input logic signed [DATA_W-1:0] v);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(topk_apply(op, v));
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup then access; ignored by the store unless empty
    task automatic write_reg(input logic sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (shadow_held == 0) begin
            if (sel == tksel_pkg::REG_CAPACITY) shadow_cap_reg = data[CAP_W-1:0];
            else shadow_largest = data[0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random value: extremes, small range for ties, near the top, or anything
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2, 3, 4: v = DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
            5, 6: begin
                if (shadow_held != 0)
                    v = shadow_kept[shadow_held-1] + DATA_W'($urandom_range(0, 2)) - 1;
                else
                    v = $urandom;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Receiver: random stall bursts while idling is on
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(1, 17) - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result checker: each transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_topk_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("[%0t] result with nothing expected: %s %0d %0b %0d %0b",
                             $realtime, "value acc cnt err",
                             o_result_value, o_accepted, o_count, o_empty_error);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_value !== exp_r.value || o_accepted !== exp_r.accepted ||
                    o_count !== exp_r.count || o_empty_error !== exp_r.empty_error) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display({"[%0t] mismatch: exp value %0d acc %0b cnt %0d err %0b,",
                                  " got value %0d acc %0b cnt %0d err %0b"},
                                 $realtime, exp_r.value, exp_r.accepted, exp_r.count,
                                 exp_r.empty_error, o_result_value, o_accepted, o_count,
                                 o_empty_error);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bounded_top_k_selector_core");
            $finish;
        end
    end

    // Pop on an empty store after reset
    task automatic test_pop_on_empty();
        send_item(tksel_pkg::OP_POP, $urandom);
    endtask

    // Field extremes in keep-smallest mode, popped worst first
    task automatic test_push_pop_extremes();
        send_item(tksel_pkg::OP_PUSH, VAL_MAX);
        send_item(tksel_pkg::OP_PUSH, VAL_MIN);
        send_item(tksel_pkg::OP_PUSH, '0);
        send_item(tksel_pkg::OP_PUSH, '1);
        repeat (5) send_item(tksel_pkg::OP_POP, $urandom);
        settle();
    endtask

    // Full store: worse rejected, equal taken, better evicts the top
    task automatic test_full_store_rules();
        write_reg(tksel_pkg::REG_CAPACITY, 32'd2);
        write_reg(tksel_pkg::REG_MODE, {31'd0, KEEP_SMALLEST});
        send_item(tksel_pkg::OP_PUSH, 32'sd5);
        send_item(tksel_pkg::OP_PUSH, 32'sd3);
        send_item(tksel_pkg::OP_PUSH, 32'sd9);
        send_item(tksel_pkg::OP_PUSH, 32'sd5);
        send_item(tksel_pkg::OP_PUSH, 32'sd1);
        settle();
    endtask

    // Register writes while values are held must be dropped
    task automatic test_config_while_busy();
        write_reg(tksel_pkg::REG_CAPACITY, 32'd31);
        write_reg(tksel_pkg::REG_MODE, {31'd0, KEEP_LARGEST});
        send_item(tksel_pkg::OP_PUSH, 32'sd4);
        send_item(tksel_pkg::OP_POP, $urandom);
        send_item(tksel_pkg::OP_POP, $urandom);
        settle();
    endtask

    // Capacity zero behaves as one, in keep-largest mode
    task automatic test_capacity_clamp();
        write_reg(tksel_pkg::REG_CAPACITY, 32'd0);
        write_reg(tksel_pkg::REG_MODE, {31'd0, KEEP_LARGEST});
        send_item(tksel_pkg::OP_PUSH, VAL_MIN);
        send_item(tksel_pkg::OP_PUSH, VAL_MAX);
        send_item(tksel_pkg::OP_PUSH, VAL_MIN);
        send_item(tksel_pkg::OP_POP, $urandom);
        settle();
    endtask

    // Mostly drain, reconfigure, then a random push/pop mix
    task automatic test_random_phase(input int unsigned n_items,
                                     input logic [CAP_W-1:0] cap_sel,
                                     input logic drain_first);
        logic [31:0] data;
        int unsigned pop_pct;
        if (drain_first) begin
            while (shadow_held != 0) send_item(tksel_pkg::OP_POP, $urandom);
        end
        settle();
        data = $urandom;
        data[CAP_W-1:0] = cap_sel;
        write_reg(tksel_pkg::REG_CAPACITY, data);
        write_reg(tksel_pkg::REG_MODE, $urandom);
        pop_pct = $urandom_range(10, 55);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < pop_pct) send_item(tksel_pkg::OP_POP, $urandom);
            else send_item(tksel_pkg::OP_PUSH, pick_value());
        end
    endtask

    initial begin
        logic [CAP_W-1:0] cap_sel;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = tksel_pkg::OP_PUSH;
        i_value        = '0;
        i_out_ready    = 1'b1;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        shadow_held    = 0;
        shadow_cap_reg = tksel_pkg::CAP_RESET;
        shadow_largest = tksel_pkg::MODE_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        stall_left     = 0;
        idle_on        = 1'b1;
        for (int i = 0; i < MAX_KEPT; i++) shadow_kept[i] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pop_on_empty();
        test_push_pop_extremes();
        test_full_store_rules();
        test_config_while_busy();
        test_capacity_clamp();

        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: cap_sel = 5'd31;
                1: cap_sel = 5'd16;
                2: cap_sel = 5'd1;
                3: cap_sel = 5'd0;
                4: cap_sel = 5'd17;
                default: cap_sel = $urandom_range(0, 31);
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            test_random_phase(105, cap_sel, $urandom_range(0, 4) != 0);
        end

        // closing stretch with both sides flat out
        idle_on = 1'b0;
        test_random_phase(150, 5'd16, 1'b1);

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS bounded_top_k_selector_core");
        end else begin
            $display("FAIL bounded_top_k_selector_core");
        end
        $finish;
    end

endmodule
